/* src/three_band_fir_equalizer_core_defines.svh */
// Assertion helpers shared by the equalizer RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef THREE_BAND_FIR_EQUALIZER_CORE_DEFINES_SVH
`define THREE_BAND_FIR_EQUALIZER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TBEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbeq: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define TBEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbeq: next-cycle check failed");

`endif

/* src/tbeq_pkg.sv */
package tbeq_pkg;

  // filter geometry
  localparam int TAPS       = 160;
  localparam int COEF_WIDTH = 16;
  localparam int TAP_AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CF_BITS    = (COEF_WIDTH < 16) ? COEF_WIDTH : 16;

  // datapath widths
  localparam int SAMP_W = 16;
  localparam int GAIN_W = 15;
  localparam int PROD_W = SAMP_W + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + TAP_AW;
  localparam int LO_W   = ACC_W / 2;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int TOT_W  = ACC_W + GAIN_W + 2;
  localparam int SHIFT  = GAIN_W + COEF_WIDTH - 1;

  // band codes
  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  // register indexes
  localparam logic [1:0] REG_LOW_GAIN  = 2'd0;
  localparam logic [1:0] REG_MID_GAIN  = 2'd1;
  localparam logic [1:0] REG_HIGH_GAIN = 2'd2;

  typedef logic signed [SAMP_W-1:0]     sample_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic [GAIN_W-1:0]            gain_t;

  // MAC lane control
  typedef struct packed {
    logic clr;  // clear accumulators for a new item
    logic vld;  // read data from the stores is valid this cycle
  } mac_ctl_t;

  // take the low CF_BITS of the coefficient field, sign-extend to the store width
  function automatic coef_t coef_ext(logic [15:0] v);
    logic signed [CF_BITS-1:0] t;
    t = v[CF_BITS-1:0];
    return COEF_WIDTH'(t);
  endfunction

endpackage

/* src/three_band_fir_equalizer_core.sv */
// Channel  Direction  Ports
// input    in         in_tvalid/in_tready, in_tdata (sample, band, tap, coef), in_tuser (kind)
// result   out        out_tvalid/out_tready, out_tdata (audio_out), out_tuser (clipped)
// config   in         psel/penable/pwrite/paddr/pwdata/prdata/pready (gains)
//
// A coefficient item is taken and gives no result.
// A sample item runs one tap per cycle through the delay-line and coefficient
// memories, then MAC drain and weighting.
// After reset a clearing pass zeroes the delay line; in_tready stays low
// meanwhile, gain writes are still taken.
// A finished result waits in the output register; a further result stalls
// in its last step until that register is free.
`include "three_band_fir_equalizer_core_defines.svh"

module three_band_fir_equalizer_core import tbeq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // audio_in[15:0], band_select[17:16], tap_index[25:18],
                                  // coef_value[41:26], zero pad[47:42]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // audio_out[15:0]
  output logic        out_tuser,  // clipped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_WEIGHT = 3'd4;
  localparam logic [2:0] ST_PUSH   = 3'd5;

  localparam logic [TAP_AW-1:0] LAST_TAP = TAP_AW'(TAPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [TAP_AW-1:0] k_r, k_nxt;
  logic [TAP_AW-1:0] ptr_r, ptr_nxt, ptr_inc;
  logic [TAP_AW-1:0] d_addr_r, d_addr_nxt;
  logic              dr_r, dr_nxt;
  logic              rd_vld_r;
  gain_t             gain_r [3];

  logic              out_tvalid_r;
  logic [15:0]       out_data_r;
  logic              out_clip_r;

  logic              in_acc, samp_acc, coef_acc, tap_ok, push, sc_start, cfg_wr;
  logic [1:0]        band;
  logic [7:0]        tap;
  logic [TAP_AW-1:0] tap_a;
  coef_t             coef_w;

  logic              dl_we;
  logic [TAP_AW-1:0] dl_waddr;
  logic [15:0]       dl_wdata, dl_rdata;
  logic [2:0]        cf_we;
  logic [COEF_WIDTH-1:0] cf_rdata [3];
  coef_t             coef_rd [3];
  acc_t              acc [3];
  mac_ctl_t          mac_ctl;

  logic              sc_done, sc_clip;
  logic [15:0]       sc_res;

  // input decode
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign samp_acc  = in_acc && !in_tuser;
  assign coef_acc  = in_acc && in_tuser;
  assign band      = in_tdata[17:16];
  assign tap       = in_tdata[25:18];
  assign tap_a     = TAP_AW'(tap);
  assign tap_ok    = (32'(tap) < 32'(TAPS));
  assign coef_w    = coef_ext(in_tdata[41:26]);
  assign ptr_inc   = (ptr_r == LAST_TAP) ? '0 : ptr_r + 1'b1;

  // delay-line write: zeroes during clearing, new sample on accept
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = ptr_inc;
    dl_wdata = in_tdata[15:0];
    if (state_r == ST_CLEAR) begin
      dl_we    = 1'b1;
      dl_waddr = k_r;
      dl_wdata = '0;
    end else if (samp_acc) begin
      dl_we = 1'b1;
    end
  end

  // coefficient store writes
  always_comb begin
    cf_we = '0;
    if (coef_acc && tap_ok) begin
      case (band)
        BAND_LOW:  cf_we[0] = 1'b1;
        BAND_MID:  cf_we[1] = 1'b1;
        BAND_HIGH: cf_we[2] = 1'b1;
        default:   cf_we    = '0;
      endcase
    end
  end

  // delay line is a circular buffer; newest sample at ptr_r
  tbeq_ram #(.DEPTH(TAPS), .WIDTH(SAMP_W), .AW(TAP_AW)) u_dline (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (d_addr_r),
    .rdata (dl_rdata)
  );

  for (genvar b = 0; b < 3; b++) begin : g_coef
    tbeq_ram #(.DEPTH(TAPS), .WIDTH(COEF_WIDTH), .AW(TAP_AW)) u_coef (
      .clk   (clk),
      .we    (cf_we[b]),
      .waddr (tap_a),
      .wdata (coef_w),
      .raddr (k_r),
      .rdata (cf_rdata[b])
    );
    assign coef_rd[b] = coef_t'(cf_rdata[b]);
  end

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    ptr_nxt    = ptr_r;
    d_addr_nxt = d_addr_r;
    dr_nxt     = dr_r;
    sc_start   = 1'b0;
    push       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        k_nxt = k_r + 1'b1;
        if (k_r == LAST_TAP) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (samp_acc) begin
          ptr_nxt    = ptr_inc;
          d_addr_nxt = ptr_inc;
          k_nxt      = '0;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        k_nxt      = k_r + 1'b1;
        d_addr_nxt = (d_addr_r == '0) ? LAST_TAP : d_addr_r - 1'b1;
        if (k_r == LAST_TAP) begin
          k_nxt     = '0;
          dr_nxt    = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        dr_nxt = 1'b1;
        if (dr_r) begin
          sc_start  = 1'b1;
          state_nxt = ST_WEIGHT;
        end
      end
      ST_WEIGHT: begin
        if (sc_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_tvalid_r || out_tready) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      k_r      <= '0;
      ptr_r    <= '0;
      d_addr_r <= '0;
      dr_r     <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      ptr_r    <= ptr_nxt;
      d_addr_r <= d_addr_nxt;
      dr_r     <= dr_nxt;
      rd_vld_r <= (state_r == ST_RUN);
    end
  end

  // MAC lanes
  assign mac_ctl = '{clr: samp_acc, vld: rd_vld_r};

  tbeq_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .samp  (sample_t'(dl_rdata)),
    .coef  (coef_rd),
    .acc   (acc)
  );

  // gain weighting and output scaling
  tbeq_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .acc   (acc),
    .gain  (gain_r),
    .done  (sc_done),
    .res   (sc_res),
    .clip  (sc_clip)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= sc_res;
      out_clip_r <= sc_clip;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // gain registers
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r[0] <= GAIN_W'(22938);
      gain_r[1] <= GAIN_W'(16384);
      gain_r[2] <= GAIN_W'(9830);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LOW_GAIN:  gain_r[0] <= pwdata[GAIN_W-1:0];
        REG_MID_GAIN:  gain_r[1] <= pwdata[GAIN_W-1:0];
        REG_HIGH_GAIN: gain_r[2] <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOW_GAIN:  prdata = 32'(gain_r[0]);
      REG_MID_GAIN:  prdata = 32'(gain_r[1]);
      REG_HIGH_GAIN: prdata = 32'(gain_r[2]);
      default:       prdata = '0;
    endcase
  end

  // checks
  `TBEQ_ASSERT_NXT(a_samp_starts_run, samp_acc, state_r == ST_RUN)
  `TBEQ_ASSERT_NXT(a_coef_no_result, coef_acc && !out_tvalid_r, !out_tvalid_r)
  `TBEQ_ASSERT_IMP(a_done_in_weight, sc_done, state_r == ST_WEIGHT)
  `TBEQ_ASSERT_IMP(a_result_from_push, $rose(out_tvalid_r), $past(state_r) == ST_PUSH)

endmodule

/* src/tbeq_ram.sv */
module tbeq_ram #(
  parameter int DEPTH = 160,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tbeq_mac.sv */
module tbeq_mac import tbeq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  sample_t  samp,
  input  coef_t    coef [3],
  output acc_t     acc  [3]
);

  prod_t prod_r [3];
  acc_t  acc_r  [3];
  logic  pv_r;

  // product valid follows read valid in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.vld;
    end
  end

  // three lanes: registered multiply, then accumulate
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ctl.vld) begin
        prod_r[i] <= coef[i] * samp;
      end
      if (ctl.clr) begin
        acc_r[i] <= '0;
      end else if (pv_r) begin
        acc_r[i] <= acc_r[i] + ACC_W'(prod_r[i]);
      end
    end
  end

  assign acc = acc_r;

endmodule

/* src/tbeq_scale.sv */
module tbeq_scale import tbeq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  acc_t              acc  [3],
  input  gain_t             gain [3],
  output logic              done,
  output logic [SAMP_W-1:0] res,
  output logic              clip
);

  localparam logic signed [TOT_W-1:0] RND  = {{(TOT_W-SHIFT){1'b0}}, {SHIFT{1'b1}}};
  localparam logic signed [TOT_W-1:0] MAXV = TOT_W'(32767);
  localparam logic signed [TOT_W-1:0] MINV = -TOT_W'(32768);

  logic [1:0]               b_r;
  logic                     mul_on_r, pv_r, fin_r, done_r;
  logic [LO_W+GAIN_W-1:0]   pp_lo_r;
  logic signed [HI_W+15:0]  pp_hi_r;
  logic signed [TOT_W-1:0]  tot_r;
  logic [SAMP_W-1:0]        res_r;
  logic                     clip_r;

  acc_t                     acc_sel;
  gain_t                    gain_sel;
  logic signed [TOT_W-1:0]  rnd_add, biased, quo;
  logic [SAMP_W-1:0]        res_nxt;
  logic                     clip_nxt;

  // band select for the shared weighting multipliers
  always_comb begin
    case (b_r)
      BAND_LOW: begin
        acc_sel  = acc[0];
        gain_sel = gain[0];
      end
      BAND_MID: begin
        acc_sel  = acc[1];
        gain_sel = gain[1];
      end
      default: begin
        acc_sel  = acc[2];
        gain_sel = gain[2];
      end
    endcase
  end

  // sequencing: three band products, then accumulate tail, then result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_on_r <= 1'b0;
      pv_r     <= 1'b0;
      fin_r    <= 1'b0;
      done_r   <= 1'b0;
      b_r      <= BAND_LOW;
    end else begin
      pv_r   <= mul_on_r;
      fin_r  <= pv_r && !mul_on_r;
      done_r <= fin_r;
      if (start) begin
        mul_on_r <= 1'b1;
        b_r      <= BAND_LOW;
      end else if (mul_on_r) begin
        if (b_r == BAND_HIGH) begin
          mul_on_r <= 1'b0;
        end else begin
          b_r <= b_r + 2'd1;
        end
      end
    end
  end

  // split multiply: low half unsigned, high half signed
  always_ff @(posedge clk) begin
    if (mul_on_r) begin
      pp_lo_r <= acc_sel[LO_W-1:0] * gain_sel;
      pp_hi_r <= $signed(acc_sel[ACC_W-1:LO_W]) * $signed({1'b0, gain_sel});
    end
    if (start) begin
      tot_r <= '0;
    end else if (pv_r) begin
      tot_r <= tot_r + (TOT_W'(pp_hi_r) <<< LO_W) + TOT_W'($signed({1'b0, pp_lo_r}));
    end
    if (fin_r) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  // rescale toward zero, then saturate
  always_comb begin
    rnd_add = tot_r[TOT_W-1] ? RND : '0;
    biased  = tot_r + rnd_add;
    quo     = biased >>> SHIFT;
    if (quo > MAXV) begin
      res_nxt  = 16'h7FFF;
      clip_nxt = 1'b1;
    end else if (quo < MINV) begin
      res_nxt  = 16'h8000;
      clip_nxt = 1'b1;
    end else begin
      res_nxt  = quo[SAMP_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign clip = clip_r;

endmodule
